// ===== src/pgm_header_parse_and_histogram_top_defines.svh =====
// Assertion macros for the PGM header parser and histogram block.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef PGM_HEADER_PARSE_AND_HISTOGRAM_TOP_DEFINES_SVH
`define PGM_HEADER_PARSE_AND_HISTOGRAM_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PGMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgmh: same-cycle check failed");

// Next-cycle implication.
`define PGMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgmh: next-cycle check failed");

`endif

// ===== src/pgmh_pkg.sv =====
// Shared types and constants of the PGM header parser and histogram block.
// No dependencies; imported by the parser, the histogram store, the top level and the testbench.
package pgmh_pkg;

  localparam int unsigned NUM_BINS     = 256;
  localparam int unsigned BIN_IDX_BITS = 8;
  localparam int unsigned OUT_DIM_BITS = 16;
  localparam int unsigned OUT_CNT_BITS = 32;

  // Characters of the file format
  localparam logic [7:0] CHR_P  = 8'h50;
  localparam logic [7:0] CHR_5  = 8'h35;
  localparam logic [7:0] CHR_SP = 8'h20;
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_0  = 8'h30;
  localparam logic [7:0] CHR_9  = 8'h39;
  localparam logic [7:0] CHR_HT = 8'h09;
  localparam logic [7:0] CHR_VT = 8'h0B;
  localparam logic [7:0] CHR_FF = 8'h0C;
  localparam logic [7:0] CHR_CR = 8'h0D;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2
  } pgmh_cmd_e;

  typedef enum logic [2:0] {
    ST_BUSY = 3'd0,
    ST_ERR  = 3'd1,
    ST_HDR  = 3'd2,
    ST_PIX  = 3'd3,
    ST_DONE = 3'd4,
    ST_BIN  = 3'd5
  } pgmh_status_e;

  // Work handed to the histogram stage
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_INC   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } pgmh_op_e;

  typedef enum logic [7:0] {
    PH_MAGIC0 = 8'b0000_0001,
    PH_MAGIC1 = 8'b0000_0010,
    PH_SEP    = 8'b0000_0100,
    PH_WIDTH  = 8'b0000_1000,
    PH_HEIGHT = 8'b0001_0000,
    PH_MAXVAL = 8'b0010_0000,
    PH_PIXELS = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } pgmh_phase_e;

  typedef struct packed {
    pgmh_op_e                op;
    logic [BIN_IDX_BITS-1:0] idx;
    pgmh_status_e            status;
    logic [OUT_DIM_BITS-1:0] width;
    logic [OUT_DIM_BITS-1:0] height;
  } pgmh_req_t;

  typedef struct packed {
    pgmh_status_e            status;
    logic [OUT_DIM_BITS-1:0] width;
    logic [OUT_DIM_BITS-1:0] height;
    logic [OUT_CNT_BITS-1:0] count;
  } pgmh_res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_0) && (b <= CHR_9);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHR_SP) || (b == CHR_HT) || (b == CHR_LF) ||
           (b == CHR_VT) || (b == CHR_FF) || (b == CHR_CR);
  endfunction

endpackage

// ===== src/pgmh_if.sv =====
// Valid/ready channel interfaces of the PGM histogram block: input and result items.
// Stand-alone; widths follow the fixed field widths of the block.
interface pgmh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic [7:0] bin_index;

  modport source (output valid, output cmd, output data_byte, output bin_index, input ready);
  modport sink   (input valid, input cmd, input data_byte, input bin_index, output ready);
endinterface

interface pgmh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [31:0] bin_count;

  modport source (output valid, output status, output image_width, output image_height,
                  output bin_count, input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  input bin_count, output ready);
endinterface

// ===== src/pgmh_parser.sv =====
// Header parser: magic, dimensions, maxval skip and pixel countdown, one byte per item.
// Depends on pgmh_pkg; feeds pgmh_hist with one request per accepted item.
module pgmh_parser #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          data_byte_i,
  input  logic [7:0]          bin_index_i,
  output pgmh_pkg::pgmh_req_t req_o
);
  import pgmh_pkg::*;

  localparam int unsigned MulBits = DIM_BITS + 4;
  localparam int unsigned PixBits = 2 * DIM_BITS;

  pgmh_phase_e         phase_q, phase_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [PixBits-1:0]  pix_left_q, pix_left_d;

  logic [3:0]          digit;
  logic [DIM_BITS-1:0] acc_src;
  logic [MulBits-1:0]  acc_mul;
  logic [DIM_BITS-1:0] acc_next;
  logic [PixBits-1:0]  pix_total;

  // Shared decimal accumulator: acc * 10 + digit, saturating
  assign digit    = 4'(data_byte_i - CHR_0);
  assign acc_src  = (phase_q == PH_HEIGHT) ? height_q : width_q;
  assign acc_mul  = (MulBits'(acc_src) << 3) + (MulBits'(acc_src) << 1) + MulBits'(digit);
  assign acc_next = (|acc_mul[MulBits-1:DIM_BITS]) ? '1 : acc_mul[DIM_BITS-1:0];

  assign pix_total = PixBits'(width_q) * PixBits'(height_q);

  // Next state and request for the item on the input
  always_comb begin
    phase_d    = phase_q;
    width_d    = width_q;
    height_d   = height_q;
    pix_left_d = pix_left_q;
    req_o.op     = OP_NONE;
    req_o.idx    = data_byte_i;
    req_o.status = ST_BUSY;

    case (cmd_i)
      CMD_BYTE: begin
        case (phase_q)
          PH_MAGIC0: begin
            if (data_byte_i != CHR_P) begin
              phase_d      = PH_ERROR;
              req_o.status = ST_ERR;
            end else begin
              phase_d = PH_MAGIC1;
            end
          end
          PH_MAGIC1: begin
            if (data_byte_i != CHR_5) begin
              phase_d      = PH_ERROR;
              req_o.status = ST_ERR;
            end else begin
              phase_d = PH_SEP;
            end
          end
          PH_SEP: begin
            phase_d = PH_WIDTH;
          end
          PH_WIDTH: begin
            if (data_byte_i == CHR_SP) begin
              phase_d = PH_HEIGHT;
            end else if (!is_digit(data_byte_i)) begin
              phase_d      = PH_ERROR;
              req_o.status = ST_ERR;
            end else begin
              width_d = acc_next;
            end
          end
          PH_HEIGHT: begin
            if (data_byte_i == CHR_LF) begin
              phase_d = PH_MAXVAL;
            end else if (!is_digit(data_byte_i)) begin
              phase_d      = PH_ERROR;
              req_o.status = ST_ERR;
            end else begin
              height_d = acc_next;
            end
          end
          PH_MAXVAL: begin
            if (is_space(data_byte_i)) begin
              pix_left_d   = pix_total;
              phase_d      = PH_PIXELS;
              req_o.status = ST_HDR;
            end else if (!is_digit(data_byte_i)) begin
              phase_d      = PH_ERROR;
              req_o.status = ST_ERR;
            end
          end
          PH_PIXELS: begin
            if (pix_left_q == '0) begin
              req_o.status = ST_DONE;
            end else begin
              req_o.op     = OP_INC;
              pix_left_d   = pix_left_q - PixBits'(1);
              req_o.status = (pix_left_q == PixBits'(1)) ? ST_DONE : ST_PIX;
            end
          end
          default: begin
            phase_d      = PH_ERROR;
            req_o.status = ST_ERR;
          end
        endcase
      end
      CMD_READ: begin
        req_o.op     = OP_READ;
        req_o.idx    = bin_index_i;
        req_o.status = ST_BIN;
      end
      CMD_START: begin
        req_o.op   = OP_CLEAR;
        phase_d    = PH_MAGIC0;
        width_d    = '0;
        height_d   = '0;
        pix_left_d = '0;
      end
      default: begin
        req_o.op = OP_NONE;
      end
    endcase

    req_o.width  = OUT_DIM_BITS'(width_d);
    req_o.height = OUT_DIM_BITS'(height_d);
  end

  // Advance parser state on accepted items only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC0;
      width_q    <= '0;
      height_q   <= '0;
      pix_left_q <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      width_q    <= width_d;
      height_q   <= height_d;
      pix_left_q <= pix_left_d;
    end
  end

endmodule

// ===== src/pgmh_hist.sv =====
// Histogram store: 256-entry synchronous bin memory with read-modify-write and forwarding.
// Depends on pgmh_pkg; takes requests from pgmh_parser, returns one result per item.
module pgmh_hist #(
  parameter int unsigned BIN_COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                accept_i,
  input  pgmh_pkg::pgmh_req_t req_i,
  output logic                res_valid_o,
  output pgmh_pkg::pgmh_res_t res_o
);
  import pgmh_pkg::*;

  logic [BIN_COUNT_BITS-1:0] mem_q [NUM_BINS];
  logic [BIN_COUNT_BITS-1:0] rdata_q;
  logic [BIN_COUNT_BITS-1:0] fwd_data_q;
  logic                      fwd_hit_q;
  logic [NUM_BINS-1:0]       bin_valid_q;
  logic                      s1_valid_q;
  pgmh_req_t                 s1_q;

  logic                      wr_en;
  logic                      entry_valid;
  logic [BIN_COUNT_BITS-1:0] old_val;
  logic [BIN_COUNT_BITS-1:0] wr_data;
  logic [BIN_COUNT_BITS-1:0] read_val;
  logic [OUT_CNT_BITS-1:0]   count_sat;

  // Merge the value written in the read cycle, then increment with saturation
  assign wr_en       = adv_i && s1_valid_q && (s1_q.op == OP_INC);
  assign entry_valid = bin_valid_q[s1_q.idx];
  assign old_val     = fwd_hit_q ? fwd_data_q : rdata_q;
  assign wr_data     = !entry_valid ? BIN_COUNT_BITS'(1) :
                       ((old_val == '1) ? old_val : old_val + BIN_COUNT_BITS'(1));
  assign read_val    = entry_valid ? old_val : '0;

  // Clamp the reported count to the output field
  if (BIN_COUNT_BITS > OUT_CNT_BITS) begin : g_clamp
    assign count_sat = (|read_val[BIN_COUNT_BITS-1:OUT_CNT_BITS]) ? '1 :
                       read_val[OUT_CNT_BITS-1:0];
  end else begin : g_extend
    assign count_sat = OUT_CNT_BITS'(read_val);
  end

  // Bin memory: one read at accept, one write when the increment leaves the stage
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rdata_q    <= mem_q[req_i.idx];
      fwd_hit_q  <= wr_en && (s1_q.idx == req_i.idx);
      fwd_data_q <= wr_data;
      s1_q       <= req_i;
    end
    if (wr_en) begin
      mem_q[s1_q.idx] <= wr_data;
    end
  end

  // Valid bits: a start clears all, and wins over an older write at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q <= '0;
    end else if (accept_i && (req_i.op == OP_CLEAR)) begin
      bin_valid_q <= '0;
    end else if (wr_en) begin
      bin_valid_q[s1_q.idx] <= 1'b1;
    end
  end

  // Stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= accept_i;
    end
  end

  assign res_valid_o  = s1_valid_q;
  assign res_o.status = s1_q.status;
  assign res_o.width  = s1_q.width;
  assign res_o.height = s1_q.height;
  assign res_o.count  = (s1_q.op == OP_READ) ? count_sat : '0;

endmodule

// ===== src/pgm_header_parse_and_histogram_top.sv =====
// Top level of the PGM (P5) header parser and 256-bin histogram.
// Depends on pgmh_pkg, pgmh_if, pgmh_parser, pgmh_hist and the defines header.
//
// The block takes one item per clock cycle, back to back, while the output is not stalled,
// and returns one result item for each: the header parser settles its state in the accept
// cycle, the bin memory is read at that edge and written back as the item leaves the
// histogram stage, and the result then sits in an output register. A bin increment
// that immediately follows another to the same gray level is served by forwarding, so a
// run of equal pixels keeps the full rate. Bins are tracked by 256 valid bits that a start
// command clears all together, so there is no clearing pass after reset. While the result
// register is full and not taken, input ready drops.
`include "pgm_header_parse_and_histogram_top_defines.svh"

module pgm_header_parse_and_histogram_top #(
  parameter int unsigned BIN_COUNT_BITS = 32,
  parameter int unsigned DIM_BITS       = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pgmh_in_if.sink         in_i,
  pgmh_out_if.source      out_o
);
  import pgmh_pkg::*;

  logic      adv;
  logic      accept;
  pgmh_req_t req;
  logic      res_valid;
  pgmh_res_t res;
  logic      out_valid_q;
  pgmh_res_t out_res_q;

  // Move the pipeline whenever the result register is free or being taken
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;

  pgmh_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (in_i.cmd),
    .data_byte_i(in_i.data_byte),
    .bin_index_i(in_i.bin_index),
    .req_o      (req)
  );

  pgmh_hist #(
    .BIN_COUNT_BITS(BIN_COUNT_BITS)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .accept_i   (accept),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_res_q.status;
  assign out_o.image_width  = out_res_q.width;
  assign out_o.image_height = out_res_q.height;
  assign out_o.bin_count    = out_res_q.count;

  // Checks
  `PGMH_ASSERT_NOW(a_stall_blocks_input, out_o.valid && !out_o.ready, !in_i.ready)
  `PGMH_ASSERT_NEXT(a_accept_fills_stage, accept, res_valid)
  `PGMH_ASSERT_NOW(a_count_only_on_read, out_o.valid && (out_o.status != ST_BIN), out_o.bin_count == '0)

endmodule

// ===== tb/pgm_header_parse_and_histogram_top_tb.sv =====
// Self-checking testbench for the PGM (P5) header parser and gray-level histogram.
// Depends on pgmh_pkg, the pgmh_in_if / pgmh_out_if channels and the top level;
// a local model of the parser and bins predicts every result item.
module pgm_header_parse_and_histogram_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pgmh_pkg::*;

  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned ITEM_GOAL  = 1200;
  localparam int unsigned GAP_PCT    = 14;
  localparam int unsigned QUIET_FROM = 300;
  localparam int unsigned QUIET_TO   = 650;
  localparam int unsigned MAX_PRINTS = 40;
  // Command code with no operation, absent from the package enum
  localparam logic [1:0]  CMD_NOP    = 2'd3;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] bin_index;
    bit         drain_first;
  } file_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pgmh_in_if  in_ch ();
  pgmh_out_if out_ch ();

  pgm_header_parse_and_histogram_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stimulus and expectations
  file_item_t  file_items[$];
  pgmh_res_t   due_results[$];
  logic [7:0]  hdr_bytes[$];
  int unsigned sent_items;
  int unsigned got_results;
  int unsigned mismatches;
  int unsigned idle_cycles;
  logic        in_fire;

  // Model state of the parser and the bins
  pgmh_phase_e phase;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [31:0] pix_left;
  logic [31:0] gray_bins[NUM_BINS];
  bit          seen_bin[NUM_BINS];

  task automatic flag_mismatch(input string what);
    mismatches++;
    // Cap the log on a badly broken block; the count still grows
    if (mismatches <= MAX_PRINTS) $display("%0t ns: result %0d: %s", $time, got_results, what);
  endtask

  function automatic void clear_image();
    phase    = PH_MAGIC0;
    img_w    = '0;
    img_h    = '0;
    pix_left = '0;
    foreach (seen_bin[i]) seen_bin[i] = 1'b0;
  endfunction

  function automatic logic [15:0] grow_dim(input logic [15:0] acc, input logic [7:0] b);
    logic [31:0] v;
    v = 32'(acc) * 32'd10 + 32'(b - CHR_0);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Advance the header parser or count a pixel
  function automatic pgmh_status_e take_file_byte(input logic [7:0] b);
    logic         is_dig;
    logic         is_ws;
    pgmh_status_e st;
    is_dig = (b >= CHR_0) && (b <= CHR_9);
    is_ws  = (b == CHR_SP) || (b == CHR_HT) || (b == CHR_LF) ||
             (b == CHR_VT) || (b == CHR_FF) || (b == CHR_CR);
    st = ST_BUSY;
    case (phase)
      PH_MAGIC0: begin
        if (b == CHR_P) phase = PH_MAGIC1;
        else begin
          phase = PH_ERROR;
          st    = ST_ERR;
        end
      end
      PH_MAGIC1: begin
        if (b == CHR_5) phase = PH_SEP;
        else begin
          phase = PH_ERROR;
          st    = ST_ERR;
        end
      end
      PH_SEP: phase = PH_WIDTH;
      PH_WIDTH: begin
        if (b == CHR_SP) phase = PH_HEIGHT;
        else if (is_dig) img_w = grow_dim(img_w, b);
        else begin
          phase = PH_ERROR;
          st    = ST_ERR;
        end
      end
      PH_HEIGHT: begin
        if (b == CHR_LF) phase = PH_MAXVAL;
        else if (is_dig) img_h = grow_dim(img_h, b);
        else begin
          phase = PH_ERROR;
          st    = ST_ERR;
        end
      end
      PH_MAXVAL: begin
        if (is_ws) begin
          pix_left = 32'(img_w) * 32'(img_h);
          phase    = PH_PIXELS;
          st       = ST_HDR;
        end else if (!is_dig) begin
          phase = PH_ERROR;
          st    = ST_ERR;
        end
      end
      PH_PIXELS: begin
        if (pix_left == '0) st = ST_DONE;
        else begin
          // First hit writes one, later hits add one and saturate
          if (!seen_bin[b]) begin
            gray_bins[b] = 32'd1;
            seen_bin[b]  = 1'b1;
          end else if (gray_bins[b] != '1) begin
            gray_bins[b] = gray_bins[b] + 32'd1;
          end
          pix_left = pix_left - 32'd1;
          st = (pix_left == '0) ? ST_DONE : ST_PIX;
        end
      end
      default: begin
        phase = PH_ERROR;
        st    = ST_ERR;
      end
    endcase
    return st;
  endfunction

  // Apply one accepted item to the model and return the result it must produce
  function automatic pgmh_res_t parse_and_count(input logic [1:0] cmd, input logic [7:0] b,
                                                input logic [7:0] idx);
    pgmh_res_t r;
    r.status = ST_BUSY;
    r.count  = '0;
    case (cmd)
      CMD_BYTE: r.status = take_file_byte(b);
      CMD_READ: begin
        r.status = ST_BIN;
        r.count  = seen_bin[idx] ? gray_bins[idx] : '0;
      end
      CMD_START: clear_image();
      default: ;
    endcase
    r.width  = img_w;
    r.height = img_h;
    return r;
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] idx,
                          input bit drain = 1'b0);
    file_item_t it;
    it.cmd         = cmd;
    it.data_byte   = b;
    it.bin_index   = idx;
    it.drain_first = drain;
    file_items.push_back(it);
  endtask

  // Unused fields carry random values so the block must ignore them
  task automatic add_byte(input logic [7:0] b);
    add_item(CMD_BYTE, b, 8'($urandom_range(255)));
  endtask

  task automatic add_read(input logic [7:0] idx);
    add_item(CMD_READ, 8'($urandom_range(255)), idx);
  endtask

  task automatic add_start(input bit drain = 1'b0);
    add_item(CMD_START, 8'($urandom_range(255)), 8'($urandom_range(255)), drain);
  endtask

  // Append decimal digits; zero may come out as an empty number or with a leading zero
  task automatic push_decimal(input int unsigned v);
    string s;
    if (v == 0 && $urandom_range(1) == 0) return;
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) hdr_bytes.push_back(CHR_0);
    for (int i = 0; i < s.len(); i++) hdr_bytes.push_back(s[i]);
  endtask

  // Build a well-formed header with random separator, maxval and terminator
  task automatic build_header(input int unsigned w, input int unsigned h);
    logic [7:0] ws[6];
    ws = '{CHR_SP, CHR_HT, CHR_LF, CHR_VT, CHR_FF, CHR_CR};
    hdr_bytes.delete();
    hdr_bytes.push_back(CHR_P);
    hdr_bytes.push_back(CHR_5);
    hdr_bytes.push_back(8'($urandom_range(255)));
    push_decimal(w);
    hdr_bytes.push_back(CHR_SP);
    push_decimal(h);
    hdr_bytes.push_back(CHR_LF);
    repeat ($urandom_range(3)) hdr_bytes.push_back(CHR_0 + 8'($urandom_range(9)));
    hdr_bytes.push_back(ws[$urandom_range(5)]);
  endtask

  // Send the header, sometimes reading a bin in the middle of parsing
  task automatic send_header();
    foreach (hdr_bytes[i]) begin
      if ($urandom_range(99) < 8) add_read(8'($urandom_range(255)));
      add_byte(hdr_bytes[i]);
    end
  endtask

  task automatic build_stimulus();
    int unsigned kind;
    int unsigned w;
    int unsigned h;
    int unsigned img;
    int unsigned spot;
    logic [7:0]  px;

    // Unwritten bin reads zero; unused command; start
    add_read(8'h00);
    add_item(CMD_NOP, 8'hFF, 8'hFF);
    add_start();
    // Bad first magic byte stays in error
    add_byte(8'h51);
    add_byte(CHR_P);
    add_start();
    // Bad second magic byte
    add_byte(CHR_P);
    add_byte(8'h34);
    // 1 x 2 image, empty maxval, extreme gray levels, a byte past the last pixel
    add_start();
    add_byte(CHR_P);
    add_byte(CHR_5);
    add_byte(8'hFF);
    add_byte(CHR_0 + 8'd1);
    add_byte(CHR_SP);
    add_byte(CHR_0 + 8'd2);
    add_byte(CHR_LF);
    add_read(8'hFF);
    add_byte(CHR_CR);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'hAA);
    add_read(8'hFF);
    add_read(8'hAA);
    // Width saturates, height empty: no pixels at all
    add_start();
    add_byte(CHR_P);
    add_byte(CHR_5);
    add_byte(8'h00);
    repeat (6) add_byte(CHR_0 + 8'd9);
    add_byte(CHR_SP);
    add_byte(CHR_LF);
    add_byte(CHR_SP);
    add_byte(8'h7F);

    // Random images: mostly well formed, some corrupted, some noise
    img = 0;
    while (file_items.size() < ITEM_GOAL) begin
      kind = $urandom_range(99);
      img++;
      add_start(img % 25 == 7);
      if (kind < 75) begin
        if (kind < 5) begin
          w = $urandom_range(200000, 65530);
          h = 0;
        end else if (kind < 9) begin
          w = $urandom_range(25, 10);
          h = $urandom_range(20, 8);
        end else begin
          w = $urandom_range(6);
          h = $urandom_range(5);
        end
        if ($urandom_range(1) == 0) {w, h} = {h, w};
        build_header(w, h);
        send_header();
        px = 8'($urandom_range(255));
        for (int unsigned p = 0; p < w * h; p++) begin
          // Runs of equal gray levels hit the forwarding path
          if ($urandom_range(99) >= 40) px = 8'($urandom_range(255));
          add_byte(px);
          if ($urandom_range(99) < 15) add_read($urandom_range(1) ? px : 8'($urandom_range(255)));
        end
        repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
        repeat ($urandom_range(3, 1)) add_read($urandom_range(1) ? px : 8'($urandom_range(255)));
      end else if (kind < 90) begin
        // Corrupt one header byte, then trail some raw bytes
        build_header($urandom_range(6), $urandom_range(6));
        spot = $urandom_range(hdr_bytes.size() - 1);
        hdr_bytes[spot] = 8'($urandom_range(255));
        send_header();
        repeat ($urandom_range(4)) add_byte(8'($urandom_range(255)));
        add_read(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(6, 1))
          add_item(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  function automatic bit skip_cycle(input int unsigned n);
    if (n >= QUIET_FROM && n < QUIET_TO) return 1'b0;
    return $urandom_range(99) < GAP_PCT;
  endfunction

  // Drive input items at the falling edge; hold valid until accepted
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_fire) begin
        if (file_items.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (file_items[0].drain_first && due_results.size() != 0) begin
          in_ch.valid <= 1'b0;
        end else if (skip_cycle(sent_items)) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid     <= 1'b1;
          in_ch.cmd       <= file_items[0].cmd;
          in_ch.data_byte <= file_items[0].data_byte;
          in_ch.bin_index <= file_items[0].bin_index;
          void'(file_items.pop_front());
        end
      end
      out_ch.ready <= !skip_cycle(got_results);
    end
  end

  // Sample both channels at the rising edge: check results, predict accepted items
  always @(posedge clk_i) begin
    pgmh_res_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("result item with none expected");
        end else begin
          want = due_results.pop_front();
          if (out_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
          if (out_ch.image_width !== want.width)
            flag_mismatch($sformatf("width %0d, want %0d", out_ch.image_width, want.width));
          if (out_ch.image_height !== want.height)
            flag_mismatch($sformatf("height %0d, want %0d", out_ch.image_height, want.height));
          if (out_ch.bin_count !== want.count)
            flag_mismatch($sformatf("bin count %0d, want %0d", out_ch.bin_count, want.count));
        end
        got_results++;
      end
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(parse_and_count(in_ch.cmd, in_ch.data_byte, in_ch.bin_index));
        sent_items++;
      end
      in_fire <= in_ch.valid && in_ch.ready;

      // Watchdog on cycles without any handshake
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_fire         = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_BYTE;
    in_ch.data_byte = '0;
    in_ch.bin_index = '0;
    out_ch.ready    = 1'b0;
    sent_items      = 0;
    got_results     = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    clear_image();
    foreach (gray_bins[i]) gray_bins[i] = '0;
    build_stimulus();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every item to go in, then for every result to come out
    while (file_items.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pgmh_pkg.sv
src/pgmh_if.sv
src/pgmh_parser.sv
src/pgmh_hist.sv
src/pgm_header_parse_and_histogram_top.sv
tb/pgm_header_parse_and_histogram_top_tb.sv
